>>> hdl/tpsa_pkg.sv
// shared constants and types for the typed page slot allocator
`timescale 1ns / 1ps
`default_nettype none
package tpsa_pkg;

  localparam int MAX_PAGES  = 1024;
  localparam int PAGE_BYTES = 4096;
  localparam int SLOT_BITS  = 8;

  localparam int PAGE_W  = $clog2(MAX_PAGES);
  localparam int USED_W  = $clog2(MAX_PAGES + 1);
  localparam int FILL_W  = $clog2(PAGE_BYTES);
  localparam int PROD_W  = 2 * FILL_W;
  localparam int ADDR_W  = 18;
  localparam int OFFS_W  = 22;
  localparam int SIZE_W  = 12;
  localparam int HDR_W   = 8;
  localparam int CIDX_W  = 2;

  localparam logic [CIDX_W-1:0] CFG_LEAF_NODE_BYTES     = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_INTERNAL_NODE_BYTES = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_HEADER_BYTES        = 2'd2;

  localparam logic OP_ALLOCATE = 1'b0;
  localparam logic OP_LOCATE   = 1'b1;

  localparam logic KIND_INTERNAL = 1'b0;
  localparam logic KIND_LEAF     = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_PAGE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [FILL_W-1:0] fill;
  } page_rec_t;

  typedef struct packed {
    logic              en;
    logic [PAGE_W-1:0] idx;
    page_rec_t         rec;
  } store_wr_t;

endpackage
`default_nettype wire

>>> hdl/tpsa_mul.sv
// shared multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module tpsa_mul (
  input  wire logic                         clk,
  input  wire logic [tpsa_pkg::FILL_W-1:0] a,
  input  wire logic [tpsa_pkg::SIZE_W-1:0] b,
  output logic      [tpsa_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= tpsa_pkg::PROD_W'(a) * tpsa_pkg::PROD_W'(b);
  end

endmodule
`default_nettype wire

>>> hdl/tpsa_store.sv
// page record memory: kind and fill count per page, registered read
`timescale 1ns / 1ps
`default_nettype none
module tpsa_store (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [tpsa_pkg::PAGE_W-1:0] rd_idx,
  output tpsa_pkg::page_rec_t               rd_rec,
  input  wire tpsa_pkg::store_wr_t          wr
);

  tpsa_pkg::page_rec_t             mem [tpsa_pkg::MAX_PAGES];
  tpsa_pkg::page_rec_t             mem_q;
  logic [tpsa_pkg::PAGE_W-1:0]     rd_idx_q;
  logic [1:0]                      written;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.rec;
    end
    mem_q    <= mem[rd_idx];
    rd_idx_q <= rd_idx;
  end

  // pages 0 and 1 come out of reset preset until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= 2'b00;
    end else if (wr.en && wr.idx < tpsa_pkg::PAGE_W'(2)) begin
      written[wr.idx[0]] <= 1'b1;
    end
  end

  always_comb begin
    rd_rec = mem_q;
    if (rd_idx_q < tpsa_pkg::PAGE_W'(2) && !written[rd_idx_q[0]]) begin
      rd_rec.kind = rd_idx_q[0];
      rd_rec.fill = '0;
    end
  end

endmodule
`default_nettype wire

>>> hdl/typed_page_slot_allocator.sv
// Top level: typed page slot allocator with a scanning sequencer.
// Locate: record read, multiply, result registered, then held in DONE until loaded.
// Allocate: each page record scanned passes through read, multiply and compare
//   states, then the write-back and offset states finish the transaction.
// One transaction in flight; the next is accepted while a result waits.
// Reset: synchronous; pages 0/1 preset via flags, no memory clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module typed_page_slot_allocator (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [tpsa_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [tpsa_pkg::SIZE_W-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         op,
  input  wire logic                         node_kind,
  input  wire logic [tpsa_pkg::ADDR_W-1:0] node_addr,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              status,
  output logic      [tpsa_pkg::ADDR_W-1:0] new_addr,
  output logic      [tpsa_pkg::OFFS_W-1:0] byte_offset
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_LRD  = 10'b0000000010,
    S_LMUL = 10'b0000000100,
    S_LFIN = 10'b0000001000,
    S_ARD  = 10'b0000010000,
    S_AMUL = 10'b0000100000,
    S_ACMP = 10'b0001000000,
    S_AWR  = 10'b0010000000,
    S_AFIN = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  localparam int PG_FULL_W = tpsa_pkg::ADDR_W - tpsa_pkg::SLOT_BITS;

  state_t state;

  logic [tpsa_pkg::SIZE_W-1:0] leaf_bytes;
  logic [tpsa_pkg::SIZE_W-1:0] internal_bytes;
  logic [tpsa_pkg::HDR_W-1:0]  header_bytes;

  logic                         kind_q;
  logic [tpsa_pkg::ADDR_W-1:0] addr_q;
  logic [tpsa_pkg::PAGE_W-1:0] idx;
  logic [tpsa_pkg::USED_W-1:0] pages_used;
  logic                         cur_match;
  logic [tpsa_pkg::FILL_W-1:0] cur_fill;
  logic [tpsa_pkg::PAGE_W-1:0] target;
  logic [tpsa_pkg::FILL_W-1:0] slot;
  logic                         res_status;
  logic [tpsa_pkg::ADDR_W-1:0] res_addr;
  logic [tpsa_pkg::OFFS_W-1:0] res_offs;

  tpsa_pkg::page_rec_t          rd_rec;
  tpsa_pkg::store_wr_t          wr;
  logic [tpsa_pkg::PAGE_W-1:0] rd_idx;
  logic [tpsa_pkg::FILL_W-1:0] mul_a;
  logic [tpsa_pkg::SIZE_W-1:0] mul_b;
  logic [tpsa_pkg::PROD_W-1:0] prod;

  logic [PG_FULL_W-1:0]         loc_page;
  logic                         loc_kind;
  logic                         fit;
  logic [tpsa_pkg::OFFS_W-1:0] alloc_offs;
  logic [tpsa_pkg::OFFS_W-1:0] loc_offs;
  logic                         load_out;

  function automatic logic [tpsa_pkg::SIZE_W-1:0] size_of(
    input logic                         kind,
    input logic [tpsa_pkg::SIZE_W-1:0] leaf_sz,
    input logic [tpsa_pkg::SIZE_W-1:0] int_sz
  );
    return (kind == tpsa_pkg::KIND_LEAF) ? leaf_sz : int_sz;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  // the page field of an address always falls inside the store
  assign loc_page = addr_q[tpsa_pkg::ADDR_W-1:tpsa_pkg::SLOT_BITS];
  assign loc_kind = rd_rec.kind;

  assign rd_idx = (state == S_LRD) ? tpsa_pkg::PAGE_W'(loc_page) : idx;

  always_comb begin
    mul_a = slot;
    mul_b = size_of(kind_q, leaf_bytes, internal_bytes);
    case (state)
      S_LMUL: begin
        mul_a = tpsa_pkg::FILL_W'(addr_q[tpsa_pkg::SLOT_BITS-1:0]);
        mul_b = size_of(loc_kind, leaf_bytes, internal_bytes);
      end
      S_AMUL: begin
        mul_a = rd_rec.fill + tpsa_pkg::FILL_W'(1);
      end
      default: begin
        mul_a = slot;
      end
    endcase
  end

  tpsa_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    wr.en       = (state == S_AWR);
    wr.idx      = target;
    wr.rec.kind = kind_q;
    wr.rec.fill = slot + tpsa_pkg::FILL_W'(1);
  end

  tpsa_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (rd_idx),
    .rd_rec (rd_rec),
    .wr     (wr)
  );

  assign fit = cur_match &&
               ((tpsa_pkg::PROD_W'(prod) + tpsa_pkg::PROD_W'(header_bytes))
                < tpsa_pkg::PROD_W'(tpsa_pkg::PAGE_BYTES));

  assign alloc_offs = (tpsa_pkg::OFFS_W'(target) << tpsa_pkg::FILL_W)
                    + tpsa_pkg::OFFS_W'(header_bytes) + tpsa_pkg::OFFS_W'(prod);
  assign loc_offs   = (tpsa_pkg::OFFS_W'(loc_page) << tpsa_pkg::FILL_W)
                    + tpsa_pkg::OFFS_W'(header_bytes) + tpsa_pkg::OFFS_W'(prod);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_bytes     <= tpsa_pkg::SIZE_W'(64);
      internal_bytes <= tpsa_pkg::SIZE_W'(128);
      header_bytes   <= tpsa_pkg::HDR_W'(16);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tpsa_pkg::CFG_LEAF_NODE_BYTES:     leaf_bytes     <= cfg_data;
        tpsa_pkg::CFG_INTERNAL_NODE_BYTES: internal_bytes <= cfg_data;
        tpsa_pkg::CFG_HEADER_BYTES:        header_bytes   <= cfg_data[tpsa_pkg::HDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pages_used <= tpsa_pkg::USED_W'(2);
      idx        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_q <= node_kind;
            addr_q <= node_addr;
            idx    <= '0;
            state  <= (op == tpsa_pkg::OP_LOCATE) ? S_LRD : S_ARD;
          end
        end
        S_LRD:  state <= S_LMUL;
        S_LMUL: state <= S_LFIN;
        S_LFIN: begin
          res_status <= tpsa_pkg::STATUS_OK;
          res_addr   <= '0;
          res_offs   <= loc_offs;
          state      <= S_DONE;
        end
        S_ARD:  state <= S_AMUL;
        S_AMUL: begin
          cur_match <= (rd_rec.kind == kind_q);
          cur_fill  <= rd_rec.fill;
          state     <= S_ACMP;
        end
        S_ACMP: begin
          if (fit) begin
            target <= idx;
            slot   <= cur_fill;
            state  <= S_AWR;
          end else if (tpsa_pkg::USED_W'(idx) + tpsa_pkg::USED_W'(1) == pages_used) begin
            if (pages_used == tpsa_pkg::USED_W'(tpsa_pkg::MAX_PAGES)) begin
              res_status <= tpsa_pkg::STATUS_NO_PAGE;
              res_addr   <= '0;
              res_offs   <= '0;
              state      <= S_DONE;
            end else begin
              // open a fresh page of the requested kind
              target     <= tpsa_pkg::PAGE_W'(pages_used);
              slot       <= '0;
              pages_used <= pages_used + tpsa_pkg::USED_W'(1);
              state      <= S_AWR;
            end
          end else begin
            idx   <= idx + tpsa_pkg::PAGE_W'(1);
            state <= S_ARD;
          end
        end
        S_AWR:  state <= S_AFIN;
        S_AFIN: begin
          res_status <= tpsa_pkg::STATUS_OK;
          res_addr   <= ({target, {tpsa_pkg::SLOT_BITS{1'b0}}})
                        | tpsa_pkg::ADDR_W'(slot);
          res_offs   <= alloc_offs;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= res_status;
      new_addr    <= res_addr;
      byte_offset <= res_offs;
    end
  end

`ifndef NO_ASSERTIONS
  a_pages_range: assert property (@(posedge clk) disable iff (rst)
    pages_used >= tpsa_pkg::USED_W'(2) &&
    pages_used <= tpsa_pkg::USED_W'(tpsa_pkg::MAX_PAGES))
    else $error("pages_used out of range");

  a_pages_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (pages_used == $past(pages_used) ||
                     pages_used == $past(pages_used) + tpsa_pkg::USED_W'(1)))
    else $error("pages_used moved by more than one");

  a_fail_only_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == tpsa_pkg::STATUS_NO_PAGE |->
      pages_used == tpsa_pkg::USED_W'(tpsa_pkg::MAX_PAGES))
    else $error("no-page status while pages remain");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result loaded outside done state");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> tpsa_pkg::USED_W'(wr.idx) < pages_used)
    else $error("page record written beyond used pages");
`endif

endmodule
`default_nettype wire
